/* hdl/otwmd_pkg.sv */
// ----------------------------------------------------------------------------
// otwmd_pkg
// Shared constants and types of the tracked-object motion detector.
// ----------------------------------------------------------------------------
`default_nettype none

package otwmd_pkg;

    localparam int DEPTH = 10;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int DVD_W = 17 + CNT_W;
    localparam int CFG_W = 16;

    localparam logic [1:0] REG_MOTION_THR = 2'd0;
    localparam logic [1:0] REG_SIZE_TOL   = 2'd1;
    localparam logic [1:0] REG_EFFECT_THR = 2'd2;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] w;
        logic [15:0] h;
    } t_smp;

    typedef struct packed {
        logic                    start;
        logic signed [DVD_W-1:0] dividend;
        logic [CNT_W-1:0]        divisor;
    } t_div_req;

    typedef struct packed {
        logic                    done;
        logic signed [DVD_W-1:0] quotient;
    } t_div_rsp;

endpackage

`default_nettype wire

/* hdl/otwmd_div.sv */
// ----------------------------------------------------------------------------
// otwmd_div
// Shared signed divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module otwmd_div (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire otwmd_pkg::t_div_req i_req,
    output otwmd_pkg::t_div_rsp      o_rsp
);
    import otwmd_pkg::*;

    localparam int STEP_W = $clog2(DVD_W);

    logic              r_busy;
    logic              r_done;
    logic              r_neg;
    logic [STEP_W-1:0] r_step;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_den;
    logic [DVD_W-1:0]  r_quo;
    logic [DVD_W-1:0]  w_mag;
    logic [CNT_W:0]    w_shift;
    logic [CNT_W:0]    w_sub;
    logic              w_ge;

    assign w_mag   = i_req.dividend[DVD_W-1] ? DVD_W'(-i_req.dividend) : DVD_W'(i_req.dividend);
    assign w_shift = {r_rem, r_quo[DVD_W-1]};
    assign w_ge    = w_shift >= {1'b0, r_den};
    assign w_sub   = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_rem  <= '0;
                r_den  <= i_req.divisor;
                r_quo  <= w_mag;
                r_neg  <= i_req.dividend[DVD_W-1];
            end else if (r_busy) begin
                r_quo  <= {r_quo[DVD_W-2:0], w_ge};
                r_rem  <= w_ge ? w_sub[CNT_W-1:0] : w_shift[CNT_W-1:0];
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_neg ? $signed(-r_quo) : $signed(r_quo);

endmodule

`default_nettype wire

/* hdl/object_track_window_motion_detect.sv */
// ----------------------------------------------------------------------------
// object_track_window_motion_detect
// Window of tracked-object samples with prefix-mean action detection and
// mean absolute deviation of position.
// ----------------------------------------------------------------------------
// Usage:
//   s-side beat: tuser = op (0 add sample, 1 restart), tdata = x, y, width,
//   height. One result beat on the m-side per input beat.
//   Thresholds are written on the cfg port while the block is idle.
// Timing:
//   all divides run through one shared divider that yields one quotient bit
//   per cycle, 21 quotient bits per divide. The prefix walk costs four
//   divides plus a test per sample up to the detecting one, the spread adds
//   two passes over n entries and four divides. s_tready is high only
//   between items.
// Reset:
//   window empty, thresholds back to 410, no result pending.
// Stall:
//   a result waits in the output register; the next item is accepted while it
//   waits, and its own result is held back until the register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module object_track_window_motion_detect (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,  // pos_x, pos_y, obj_width, obj_height
    input  wire logic [0:0]  s_axis_tuser,  // op
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // sample_count, action_detected, shape_changed, motion_detected,
    // effects_valid, spread_x, spread_y, moved_x, moved_y, zero fill
    output logic [47:0]      m_axis_tdata,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [15:0] i_cfg_wdata
);
    import otwmd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CHK, S_PRE_DIV, S_PRE_WAIT, S_PRE_TEST, S_SUM, S_MEAN_X,
        S_MEAN_XW, S_MEAN_Y, S_MEAN_YW, S_DEV, S_SPR_X, S_SPR_XW, S_SPR_Y,
        S_SPR_YW, S_OUT
    } t_state;

    t_state                  r_state;
    t_smp                    r_win [DEPTH];
    logic [IDX_W-1:0]        r_slot;
    logic [CNT_W-1:0]        r_cnt;
    logic [IDX_W-1:0]        r_k;
    logic [IDX_W-1:0]        r_j;
    logic [1:0]              r_ch;
    logic signed [16:0]      r_mean [4];
    logic signed [16:0]      r_mx;
    logic signed [16:0]      r_my;
    logic signed [DVD_W-1:0] r_sx;
    logic signed [DVD_W-1:0] r_sy;
    logic [15:0]             r_spx;
    logic [15:0]             r_spy;
    logic                    r_act;
    logic                    r_shp;
    logic                    r_mot;
    logic [11:0]             r_mthr;
    logic [11:0]             r_stol;
    logic [15:0]             r_ethr;
    logic                    r_ovalid;
    logic [47:0]             r_odata;

    t_smp                    w_v;
    logic signed [16:0]      w_vc;
    logic signed [DVD_W-1:0] w_prod;
    logic [CNT_W:0]          w_start;
    logic [IDX_W-1:0]        w_jnext;
    logic signed [17:0]      w_dx;
    logic signed [17:0]      w_dy;
    logic signed [17:0]      w_dw;
    logic signed [17:0]      w_dh;
    logic [17:0]             w_ax;
    logic [17:0]             w_ay;
    logic [17:0]             w_aw;
    logic [17:0]             w_ah;
    logic                    w_sz;
    logic                    w_ps;
    logic signed [17:0]      w_ex;
    logic signed [17:0]      w_ey;
    logic [17:0]             w_aex;
    logic [17:0]             w_aey;
    logic                    w_jlast;
    logic                    w_klast;
    t_div_req                w_req;
    t_div_rsp                w_rsp;

    otwmd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign w_v = r_win[r_j];

    always_comb begin
        case (r_ch)
            2'd0:    w_vc = 17'($signed(w_v.x));
            2'd1:    w_vc = 17'($signed(w_v.y));
            2'd2:    w_vc = $signed({1'b0, w_v.w});
            default: w_vc = $signed({1'b0, w_v.h});
        endcase
    end

    assign w_prod  = DVD_W'($signed({1'b0, r_k})) * DVD_W'(r_mean[r_ch]);
    assign w_start = ({1'b0, CNT_W'(r_slot)} >= {1'b0, r_cnt})
                   ? {1'b0, CNT_W'(r_slot)} - {1'b0, r_cnt}
                   : {1'b0, CNT_W'(r_slot)} + (CNT_W + 1)'(DEPTH) - {1'b0, r_cnt};
    assign w_jnext = (r_j == IDX_W'(DEPTH - 1)) ? '0 : r_j + 1'b1;
    assign w_jlast = CNT_W'(r_j) == r_cnt - 1'b1;
    assign w_klast = CNT_W'(r_k) == r_cnt - 1'b1;

    assign w_dx = 18'(r_mean[0]) - 18'($signed(w_v.x));
    assign w_dy = 18'(r_mean[1]) - 18'($signed(w_v.y));
    assign w_dw = 18'(r_mean[2]) - $signed({2'b00, w_v.w});
    assign w_dh = 18'(r_mean[3]) - $signed({2'b00, w_v.h});
    assign w_ax = w_dx[17] ? 18'(-w_dx) : 18'(w_dx);
    assign w_ay = w_dy[17] ? 18'(-w_dy) : 18'(w_dy);
    assign w_aw = w_dw[17] ? 18'(-w_dw) : 18'(w_dw);
    assign w_ah = w_dh[17] ? 18'(-w_dh) : 18'(w_dh);
    assign w_ps = (w_ax > 18'(r_mthr)) || (w_ay > 18'(r_mthr));
    assign w_sz = ({w_aw, 12'd0} > 30'(r_stol) * 30'(w_v.w))
               || ({w_ah, 12'd0} > 30'(r_stol) * 30'(w_v.h));

    assign w_ex  = 18'($signed(w_v.x)) - 18'(r_mx);
    assign w_ey  = 18'($signed(w_v.y)) - 18'(r_my);
    assign w_aex = w_ex[17] ? 18'(-w_ex) : 18'(w_ex);
    assign w_aey = w_ey[17] ? 18'(-w_ey) : 18'(w_ey);

    always_comb begin
        w_req.start    = 1'b0;
        w_req.dividend = r_sx;
        w_req.divisor  = r_cnt;
        case (r_state)
            S_PRE_DIV: begin
                w_req.start    = 1'b1;
                w_req.dividend = w_prod + DVD_W'(w_vc);
                w_req.divisor  = CNT_W'(r_k) + 1'b1;
            end
            S_MEAN_X, S_SPR_X: begin
                w_req.start = 1'b1;
            end
            S_MEAN_Y, S_SPR_Y: begin
                w_req.start    = 1'b1;
                w_req.dividend = r_sy;
            end
            default: begin
                w_req.start = 1'b0;
            end
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mthr <= 12'd410;
            r_stol <= 12'd410;
            r_ethr <= 16'd410;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_MOTION_THR: r_mthr <= i_cfg_wdata[11:0];
                REG_SIZE_TOL:   r_stol <= i_cfg_wdata[11:0];
                REG_EFFECT_THR: r_ethr <= i_cfg_wdata;
                default:        r_ethr <= r_ethr;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_slot   <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && m_axis_tready && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_act <= 1'b0;
                        r_shp <= 1'b0;
                        r_mot <= 1'b0;
                        r_spx <= '0;
                        r_spy <= '0;
                        if (s_axis_tuser[0]) begin
                            r_slot <= '0;
                            r_cnt  <= '0;
                        end else begin
                            r_win[r_slot] <= t_smp'({s_axis_tdata[15:0], s_axis_tdata[31:16],
                                                     s_axis_tdata[47:32], s_axis_tdata[63:48]});
                            r_slot <= (r_slot == IDX_W'(DEPTH - 1)) ? '0 : r_slot + 1'b1;
                            if (r_cnt != CNT_W'(DEPTH)) begin
                                r_cnt <= r_cnt + 1'b1;
                            end
                        end
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    r_k       <= '0;
                    r_ch      <= '0;
                    r_sx      <= '0;
                    r_sy      <= '0;
                    r_mean[0] <= '0;
                    r_mean[1] <= '0;
                    r_mean[2] <= '0;
                    r_mean[3] <= '0;
                    if (r_cnt >= CNT_W'(2)) begin
                        r_j     <= w_start[IDX_W-1:0];
                        r_state <= S_PRE_DIV;
                    end else if (r_cnt != '0) begin
                        r_j     <= '0;
                        r_state <= S_SUM;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_PRE_DIV: begin
                    r_state <= S_PRE_WAIT;
                end
                S_PRE_WAIT: begin
                    if (w_rsp.done) begin
                        r_mean[r_ch] <= w_rsp.quotient[16:0];
                        r_ch         <= r_ch + 1'b1;
                        r_state      <= (r_ch == 2'd3) ? S_PRE_TEST : S_PRE_DIV;
                    end
                end
                S_PRE_TEST: begin
                    if (w_sz || w_ps || w_klast) begin
                        r_act   <= w_sz || w_ps;
                        r_shp   <= w_sz;
                        r_mot   <= w_ps;
                        r_j     <= '0;
                        r_state <= S_SUM;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_j     <= w_jnext;
                        r_state <= S_PRE_DIV;
                    end
                end
                S_SUM: begin
                    r_sx <= r_sx + DVD_W'($signed(w_v.x));
                    r_sy <= r_sy + DVD_W'($signed(w_v.y));
                    r_j  <= r_j + 1'b1;
                    if (w_jlast) begin
                        r_state <= S_MEAN_X;
                    end
                end
                S_MEAN_X: begin
                    r_state <= S_MEAN_XW;
                end
                S_MEAN_XW: begin
                    if (w_rsp.done) begin
                        r_mx    <= w_rsp.quotient[16:0];
                        r_state <= S_MEAN_Y;
                    end
                end
                S_MEAN_Y: begin
                    r_state <= S_MEAN_YW;
                end
                S_MEAN_YW: begin
                    if (w_rsp.done) begin
                        r_my    <= w_rsp.quotient[16:0];
                        r_j     <= '0;
                        r_sx    <= '0;
                        r_sy    <= '0;
                        r_state <= S_DEV;
                    end
                end
                S_DEV: begin
                    r_sx <= r_sx + DVD_W'(w_aex);
                    r_sy <= r_sy + DVD_W'(w_aey);
                    r_j  <= r_j + 1'b1;
                    if (w_jlast) begin
                        r_state <= S_SPR_X;
                    end
                end
                S_SPR_X: begin
                    r_state <= S_SPR_XW;
                end
                S_SPR_XW: begin
                    if (w_rsp.done) begin
                        r_spx   <= w_rsp.quotient[15:0];
                        r_state <= S_SPR_Y;
                    end
                end
                S_SPR_Y: begin
                    r_state <= S_SPR_YW;
                end
                S_SPR_YW: begin
                    if (w_rsp.done) begin
                        r_spy   <= w_rsp.quotient[15:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {6'd0, (r_spy > r_ethr), (r_spx > r_ethr), r_spy, r_spx,
                                     (r_cnt != '0), r_mot, r_shp, r_act, r_cnt[3:0]};
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* hdl/otwmd_checker.sv */
// ----------------------------------------------------------------------------
// otwmd_checker
// Port-level checks of the motion detector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module otwmd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [47:0] m_axis_tdata
);

    // ready drops right after an accepted beat
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready right after accepted beat");

    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed under stall");

    // action needs two samples
    a_action_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[4] |-> m_axis_tdata[3:0] != 4'd0
            && m_axis_tdata[3:0] != 4'd1)
        else $error("action with fewer than two samples");

    a_action_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[4] |-> m_axis_tdata[6:5] == 2'b00)
        else $error("kind flag without action");

    a_empty_spread: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[7] |-> m_axis_tdata[41:8] == 34'd0)
        else $error("spread on empty window");

endmodule

bind object_track_window_motion_detect otwmd_checker u_otwmd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
